/* design/smug_pkg.sv */
`timescale 1ns / 1ps

package smug_pkg;

    // shuffle table geometry (depth is a power of two)
    localparam int TABLE_DEPTH  = 32;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int IDX_SHIFT    = 31 - IDX_W;
    localparam int WARMUP_STEPS = 8;
    localparam int INIT_STEPS   = TABLE_DEPTH + WARMUP_STEPS;
    localparam int CNT_W        = $clog2(INIT_STEPS);

    // generator arithmetic
    localparam int                   MULT_W      = 15;
    localparam int                   PROD_W      = 32 + MULT_W;
    localparam logic [MULT_W-1:0]    LCG_MULT    = 15'd16807;
    localparam logic [31:0]          LCG_MOD     = 32'h7FFF_FFFF;
    localparam logic [30:0]          CLAMP_LIMIT = 31'd2147483390;

    // input word kinds
    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic             load_seed;
        logic             init_start;
        logic             mul;
        logic             rd;
        logic             init_red;
        logic             draw_red;
        logic [CNT_W-1:0] step;
    } smug_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_init;
    } smug_status_t;

endpackage

/* design/smug_ctrl.sv */
`timescale 1ns / 1ps

module smug_ctrl
    import smug_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_func,
    output logic         in_ready,
    input  logic         out_ready,
    output logic         out_valid,
    input  smug_status_t status,
    output smug_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.step       = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == FUNC_LOAD)
                    begin
                        cmd.load_seed = 1'b1;
                    end
                    else if (status.need_init)
                    begin
                        cmd.init_start = 1'b1;
                        cnt_next       = CNT_W'(INIT_STEPS - 1);
                        state_next     = ST_INIT_MUL;
                    end
                    else
                    begin
                        cmd.mul    = 1'b1;
                        cmd.rd     = 1'b1;
                        state_next = ST_DRAW_RED;
                    end
                end
            end
            ST_INIT_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_INIT_RED;
            end
            ST_INIT_RED:
            begin
                cmd.init_red = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DRAW_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_INIT_MUL;
                end
            end
            ST_DRAW_MUL:
            begin
                cmd.mul    = 1'b1;
                cmd.rd     = 1'b1;
                state_next = ST_DRAW_RED;
            end
            ST_DRAW_RED:
            begin
                // hold until the output register can take the word
                if (out_free)
                begin
                    cmd.draw_red = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.draw_red)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/smug_dpath.sv */
`timescale 1ns / 1ps

module smug_dpath
    import smug_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [31:0]  seed_value,
    input  smug_cmd_t    cmd,
    output smug_status_t status,
    output logic [30:0]  sample,
    output logic         clamped
);

    logic [31:0]       lcg_reg, lcg_next;
    logic [30:0]       sout_reg, sout_next;
    logic [PROD_W-1:0] prod_reg;
    logic [30:0]       rd_data_reg;
    logic [30:0]       sample_reg;
    logic              clamped_reg;
    logic [30:0]       tbl_mem [TABLE_DEPTH];

    logic [31:0]       start_val;
    logic [31:0]       fold_sum;
    logic [30:0]       red_val;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;

    assign status.need_init = (lcg_reg == '0) || lcg_reg[31] || (sout_reg == '0);

    // start value: one for a non-negative seed, else its magnitude
    assign start_val = lcg_reg[31] ? (~lcg_reg + 32'd1) : 32'd1;

    // mod 2^31-1 reduction: fold high bits onto low bits, subtract once
    assign fold_sum = {1'b0, prod_reg[30:0]} + 32'(prod_reg[PROD_W-1:31]);
    always_comb
    begin
        if (fold_sum >= LCG_MOD)
            red_val = 31'(fold_sum - LCG_MOD);
        else
            red_val = fold_sum[30:0];
    end

    // table index from the top bits of the last output
    assign rd_idx = IDX_W'(sout_reg >> IDX_SHIFT);

    // table write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx;
        if (cmd.init_red && (cmd.step < CNT_W'(TABLE_DEPTH)))
        begin
            wr_en   = 1'b1;
            wr_addr = cmd.step[IDX_W-1:0];
        end
        else if (cmd.draw_red)
        begin
            wr_en = 1'b1;
        end
    end

    // generator state and shuffle output
    always_comb
    begin
        lcg_next  = lcg_reg;
        sout_next = sout_reg;
        if (cmd.load_seed)
            lcg_next = seed_value;
        else if (cmd.init_start)
            lcg_next = start_val;
        else if (cmd.init_red || cmd.draw_red)
            lcg_next = {1'b0, red_val};
        if (cmd.init_red && (cmd.step == '0))
            sout_next = red_val;
        else if (cmd.draw_red)
            sout_next = rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg  <= '0;
            sout_reg <= '0;
        end
        else
        begin
            lcg_reg  <= lcg_next;
            sout_reg <= sout_next;
        end
    end

    // multiplier register
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= PROD_W'(lcg_reg) * PROD_W'(LCG_MULT);
    end

    // shuffle table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            tbl_mem[wr_addr] <= red_val;
        if (cmd.rd)
            rd_data_reg <= tbl_mem[rd_idx];
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.draw_red)
        begin
            sample_reg  <= rd_data_reg;
            clamped_reg <= (rd_data_reg >= CLAMP_LIMIT);
        end
    end

    assign sample  = sample_reg;
    assign clamped = clamped_reg;

endmodule

/* design/shuffled_minstd_uniform_generator.sv */
`timescale 1ns / 1ps
// A load word writes the seed into the generator register. A draw word registers the product
// and the table read, then, once the output register is free, reduces and writes back the
// entry and registers the result word; no new word is taken meanwhile. A draw that needs
// initialization loads the start value, then 40 steps (multiplier register, modular fold).
// Reset: generator value and shuffle output clear to zero, so the first draw initializes.
module shuffled_minstd_uniform_generator
    import smug_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed_value
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] sample, [31] zero
    output logic        m_tuser    // [0] clamped
);

    smug_cmd_t    cmd;
    smug_status_t status;
    logic [30:0]  sample;

    smug_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_func   (s_tuser),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .status    (status),
        .cmd       (cmd)
    );

    smug_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_value (s_tdata),
        .cmd        (cmd),
        .status     (status),
        .sample     (sample),
        .clamped    (m_tuser)
    );

    assign m_tdata = {1'b0, sample};

    // at most one state update command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_seed, cmd.init_start, cmd.init_red, cmd.draw_red}))
        else $error("conflicting datapath commands");

    // a finished draw always shows a word on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw_red |=> m_tvalid)
        else $error("draw finished without output word");

    // no new word is taken while initialization runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_start |=> !s_tready)
        else $error("input accepted during initialization");

    // a draw finishes only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw_red |-> (!m_tvalid || m_tready))
        else $error("output word overwritten");

endmodule

/* verif/shuffled_minstd_uniform_generator_test.sv */
`timescale 1ns / 1ps

module shuffled_minstd_uniform_generator_test;
    import smug_pkg::*;

    localparam logic [63:0] MINSTD_MOD   = 64'd2147483647;
    localparam logic [63:0] MINSTD_MULT  = 64'd16807;
    // multiplicative inverse of 16807 modulo 2^31-1, used to plant chosen values
    localparam logic [63:0] MINSTD_INV   = 64'd1407677000;
    localparam int unsigned SLOT_SPAN    = 1 + 2147483646 / TABLE_DEPTH;
    localparam logic [30:0] CLAMP_FLOOR  = 31'd2147483390;
    localparam int          TOTAL_WORDS  = 1600;
    localparam int          CALM_FROM    = 1350;
    localparam int          BURST_PAIRS  = 40;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [30:0] sample;
        logic        clamped;
    } sample_t;

    // predicts the shuffled generator output and checks each result word
    class minstd_scoreboard;
        logic [31:0] gen_value;
        logic [30:0] last_out;
        logic [30:0] shuffle_tbl [TABLE_DEPTH];
        sample_t     pending_q [$];
        int          errors;
        int          n_checked;

        function new();
            gen_value = '0;
            last_out  = '0;
            foreach (shuffle_tbl[i]) shuffle_tbl[i] = '0;
            errors    = 0;
            n_checked = 0;
        endfunction

        function logic [63:0] minstd_step(logic [63:0] x);
            return (x * MINSTD_MULT) % MINSTD_MOD;
        endfunction

        // warm up from the start value and fill the table top down
        function void reseed_table();
            logic [63:0] x;
            int          j;
            if (!gen_value[31])
                x = 64'd1;
            else
                x = {32'd0, (~gen_value) + 32'd1};
            if (x == 64'd0)
                x = 64'h8000_0000;
            for (j = TABLE_DEPTH + WARMUP_STEPS - 1; j >= 0; j--)
            begin
                x = minstd_step(x);
                if (j < TABLE_DEPTH)
                    shuffle_tbl[j] = x[30:0];
            end
            gen_value = x[31:0];
            last_out  = shuffle_tbl[0];
        endfunction

        // accepted input word: load the seed or predict one draw
        function void note(logic func, logic [31:0] seed);
            logic [63:0] nxt;
            int          idx;
            sample_t     s;
            if (func == FUNC_LOAD)
            begin
                gen_value = seed;
                return;
            end
            if (gen_value == 32'd0 || gen_value[31] || last_out == 31'd0)
                reseed_table();
            nxt       = minstd_step({32'd0, gen_value});
            gen_value = nxt[31:0];
            idx = int'({1'b0, last_out} / SLOT_SPAN);
            if (idx >= TABLE_DEPTH)
                idx = TABLE_DEPTH - 1;
            last_out         = shuffle_tbl[idx];
            shuffle_tbl[idx] = gen_value[30:0];
            s.sample  = last_out;
            s.clamped = (last_out >= CLAMP_FLOOR);
            pending_q.push_back(s);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // accepted result word against the oldest prediction
        task check(logic [31:0] data, logic user);
            sample_t want;
            n_checked++;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected word sample %0d clamped %0b", data[30:0], user));
                return;
            end
            want = pending_q.pop_front();
            if (data[30:0] !== want.sample)
                report($sformatf("sample %0d, predicted %0d", data[30:0], want.sample));
            if (data[31] !== 1'b0)
                report("upper tdata bit not zero");
            if (user !== want.clamped)
                report($sformatf("clamped %0b, predicted %0b", user, want.clamped));
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] seed_value
    logic        s_tuser  = 1'b0; // [0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [30:0] sample, [31] zero
    logic        m_tuser;         // [0] clamped

    minstd_scoreboard sb = new();
    int               n_sent   = 0;
    int               n_bursts = 0;
    bit               did_hold = 1'b0;

    shuffled_minstd_uniform_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hold reset, then release it
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watch both handshakes
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tdata, m_tuser);
        if (rst_n && s_tvalid && s_tready)
            sb.note(s_tuser, s_tdata);
    end

    // offer one word and wait for it to be taken
    task send_word(input logic func, input logic [31:0] seed);
        if (n_sent < CALM_FROM && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= seed;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_sent++;
    endtask

    task draw_words(input int count);
        repeat (count) send_word(FUNC_DRAW, $urandom);
    endtask

    // plant values near the top of the range so the clamp flag shows up
    task clamp_burst();
        logic [63:0] target;
        logic [63:0] plant;
        target = {33'd0, CLAMP_FLOOR} + 64'($urandom_range(0, 256));
        plant  = (target * MINSTD_INV) % MINSTD_MOD;
        repeat (BURST_PAIRS)
        begin
            send_word(FUNC_LOAD, plant[31:0]);
            send_word(FUNC_DRAW, $urandom);
        end
        n_bursts++;
    endtask

    function automatic logic [31:0] pick_seed();
        logic [31:0] seed;
        case ($urandom_range(0, 4))
            0: seed = $urandom;
            1: seed = $urandom_range(1, 2147483646);
            2: seed = 32'd0 - 32'($urandom_range(1, 2147483647));
            3:
            begin
                case ($urandom_range(0, 4))
                    0: seed = 32'h0000_0000;
                    1: seed = 32'h8000_0000;
                    2: seed = 32'h7FFF_FFFF;
                    3: seed = 32'hFFFF_FFFF;
                    default: seed = 32'h0000_0001;
                endcase
            end
            default: seed = $urandom | 32'h8000_0000;
        endcase
        return seed;
    endfunction

    // stimulus
    initial
    begin
        int kind;
        wait (rst_n);
        @(posedge clk);

        // the first draw after reset initializes from one
        draw_words(2);
        // zero and minus one both start from one
        send_word(FUNC_LOAD, 32'h0000_0000);
        draw_words(1);
        send_word(FUNC_LOAD, 32'hFFFF_FFFF);
        draw_words(1);
        // most negative seed, magnitude 2^31
        send_word(FUNC_LOAD, 32'h8000_0000);
        draw_words(1);
        send_word(FUNC_LOAD, 32'h8000_0001);
        draw_words(1);
        // seed equal to the modulus steps to zero and forces a reinit
        send_word(FUNC_LOAD, 32'h7FFF_FFFF);
        draw_words(3);
        send_word(FUNC_LOAD, 32'h0000_0001);
        draw_words(1);
        send_word(FUNC_LOAD, 32'h7FFF_FFFE);
        draw_words(1);
        send_word(FUNC_LOAD, 32'd12345);
        draw_words(2);
        // back to back loads, only the last one counts
        send_word(FUNC_LOAD, 32'd5);
        send_word(FUNC_LOAD, 32'hFFFF_FFF9);
        draw_words(1);

        // random mix, mostly runs of draws
        while (n_sent < TOTAL_WORDS)
        begin
            kind = $urandom_range(0, 99);
            if (n_bursts == 0 && n_sent > 600)
                kind = 99;
            if (kind < 60)
                draw_words($urandom_range(1, 12));
            else if (kind < 82)
            begin
                send_word(FUNC_LOAD, pick_seed());
                draw_words($urandom_range(1, 6));
            end
            else if (kind < 90)
            begin
                send_word(FUNC_LOAD, pick_seed());
                send_word(FUNC_LOAD, pick_seed());
                draw_words(1);
            end
            else if (kind < 96)
            begin
                send_word(FUNC_LOAD, 32'h7FFF_FFFF);
                draw_words($urandom_range(2, 8));
            end
            else if (n_bursts < 3)
                clamp_burst();
            else
                draw_words(1);
        end
        s_tvalid <= 1'b0;

        // drain
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!did_hold && sb.n_checked >= 150)
            begin
                did_hold = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (n_sent < CALM_FROM && $urandom_range(0, 99) < 10)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* shuffled_minstd_uniform_generator.f */
design/smug_pkg.sv
design/smug_ctrl.sv
design/smug_dpath.sv
design/shuffled_minstd_uniform_generator.sv
verif/shuffled_minstd_uniform_generator_test.sv
